### src/pwm_timer_setting_controller_defines.svh
// Assertion macros for the PWM timer setting controller.
`ifndef PWM_TIMER_SETTING_CONTROLLER_DEFINES_SVH
`define PWM_TIMER_SETTING_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTS_ASSERT(label, clk, rst_n, prop, msg)
`define PTS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### src/pts_pkg.sv
// Types and constants shared by the PWM timer setting controller.
package pts_pkg;
  localparam logic [31:0] RECORD_MAGIC = 32'h5057_4D53;
  localparam logic [19:0] FREQ_RESET   = 20'd10000;
  // ceil(2^30 / 100): exact floor division by 100 for numerators below 2^23
  localparam logic [23:0] PULSE_RECIP  = 24'd10737419;

  typedef enum logic [3:0] {
    ACT_SETFREQ = 4'd0, ACT_SETDUTY = 4'd1, ACT_INCFREQ = 4'd2,
    ACT_DECFREQ = 4'd3, ACT_INCDUTY = 4'd4, ACT_DECDUTY = 4'd5,
    ACT_LOAD    = 4'd6, ACT_SAVED   = 4'd7, ACT_RETIME  = 4'd8
  } action_t;

  typedef enum logic [1:0] {
    CFG_MIN_FREQ = 2'd0, CFG_MAX_FREQ = 2'd1, CFG_FREQ_STEP = 2'd2, CFG_DUTY_STEP = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] frequency_in;
    logic [7:0]  duty_in;
    logic [31:0] now_ms;
    logic [31:0] record_magic;
    logic [31:0] record_checksum;
    logic        save_ok;
  } in_req_t;

  typedef struct packed {
    logic [19:0] frequency_out;
    logic [6:0]  duty_out;
    logic [15:0] prescaler_out;
    logic [15:0] period_out;
    logic [16:0] pulse_out;
    logic        dirty_out;
    logic [31:0] dirty_time_out;
    logic        load_ok;
  } out_req_t;

  // controller -> datapath
  typedef struct packed {
    logic apply;     // apply command using the request at the input
    logic tm_start;  // start timer search
    logic div_start; // start divider
    logic pulse;     // compute pulse numerator
    logic pul_start; // scale pulse numerator by 1/100
    logic finish;    // reserved; the result is written through load_res
  } pts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic search_done;
  } pts_sts_t;
endpackage

### src/pts_div.sv
// Restoring divider, one quotient bit per cycle.
module pts_div import pts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] q_r, q_nxt, d_r, d_nxt;
  logic [32:0] rem_r, rem_nxt, trial;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {rem_r[31:0], q_r[31]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend; d_nxt = divisor; rem_nxt = '0; cnt_nxt = 6'd32; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial; q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[31]}; q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
  end

  assign done     = !busy_r && !start;
  assign quotient = q_r;
endmodule

### src/pts_datapath.sv
// Settings registers, command apply, prescaler search and pulse math.
module pts_datapath import pts_pkg::*; #(
  parameter int unsigned CLOCK_HZ   = 72000000,
  parameter int unsigned PERIOD_MAX = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_sel,
  input  logic [19:0] cfg_data,
  input  in_req_t     req,
  input  pts_cmd_t    cmd,
  output pts_sts_t    sts,
  output out_req_t    res
);
  localparam logic [31:0] CLK_W = 32'(CLOCK_HZ);
  localparam logic [31:0] PMAX  = 32'(PERIOD_MAX);

  logic [19:0] min_f_r, max_f_r, fstep_r;
  logic [6:0]  dstep_r;
  logic [19:0] freq_r, freq_nxt;
  logic [6:0]  duty_r, duty_nxt;
  logic [15:0] pre_r, per_r;
  logic        dirty_r, dirty_nxt, lok_r, lok_nxt;
  logic [31:0] dtime_r, dtime_nxt;

  // search state
  logic [15:0] p_r;      // prescaler of the trial in progress
  logic [31:0] ticks_r;  // clk/(p+1) of the trial in progress
  logic        phase_r;  // 0: clk/(p+1), 1: /f
  logic        srch_r, dgo_r, dgo_nxt;
  logic        more0, more, step_ok;
  logic [31:0] dvd, dvs, quo;
  logic        ddone, dstart;
  logic [23:0] num_r;
  logic [16:0] pulse_r;
  logic [47:0] pprod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_f_r <= 20'd1000; max_f_r <= 20'd200000; fstep_r <= 20'd1000; dstep_r <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_sel))
        CFG_MIN_FREQ:  min_f_r <= cfg_data;
        CFG_MAX_FREQ:  max_f_r <= cfg_data;
        CFG_FREQ_STEP: fstep_r <= cfg_data;
        CFG_DUTY_STEP: dstep_r <= cfg_data[6:0];
      endcase
    end
  end

  // command apply, using the request presented at the input
  logic [31:0] fset, fc;
  logic [20:0] fsum;
  logic [19:0] finc;
  logic [7:0]  dsum, dset;
  always_comb begin
    freq_nxt = freq_r; duty_nxt = duty_r; dirty_nxt = dirty_r;
    dtime_nxt = dtime_r; lok_nxt = 1'b0;
    fsum = {1'b0, freq_r} + {1'b0, fstep_r};
    dsum = {1'b0, duty_r} + {1'b0, dstep_r};
    fset = req.frequency_in;
    dset = (req.duty_in > 8'd100) ? 8'd100 : req.duty_in;
    fc = (fset < {12'd0, min_f_r}) ? {12'd0, min_f_r} : fset;
    fc = (fc > {12'd0, max_f_r}) ? {12'd0, max_f_r} : fc;
    // raise to min, then lower to max, as for a direct set
    finc = (fsum[19:0] < min_f_r) ? min_f_r : fsum[19:0];
    finc = (finc > max_f_r) ? max_f_r : finc;
    unique case (req.action)
      ACT_SETFREQ: begin
        freq_nxt = fc[19:0]; dirty_nxt = 1'b1; dtime_nxt = req.now_ms;
      end
      ACT_SETDUTY: begin
        duty_nxt = dset[6:0]; dirty_nxt = 1'b1; dtime_nxt = req.now_ms;
      end
      ACT_INCFREQ: if (fsum <= {1'b0, max_f_r}) begin
        freq_nxt = finc;
        dirty_nxt = 1'b1; dtime_nxt = req.now_ms;
      end
      ACT_DECFREQ: if (fstep_r <= freq_r && (freq_r - fstep_r) >= min_f_r) begin
        freq_nxt = ((freq_r - fstep_r) > max_f_r) ? max_f_r : freq_r - fstep_r;
        dirty_nxt = 1'b1; dtime_nxt = req.now_ms;
      end
      ACT_INCDUTY: if (dsum <= 8'd100) begin
        duty_nxt = dsum[6:0]; dirty_nxt = 1'b1; dtime_nxt = req.now_ms;
      end
      ACT_DECDUTY: if (dstep_r <= duty_r) begin
        duty_nxt = duty_r - dstep_r; dirty_nxt = 1'b1; dtime_nxt = req.now_ms;
      end
      ACT_LOAD: if (req.record_magic == RECORD_MAGIC &&
                    req.record_checksum == (req.record_magic ^ req.frequency_in ^
                                            {24'd0, req.duty_in}) &&
                    req.frequency_in >= {12'd0, min_f_r} &&
                    req.frequency_in <= {12'd0, max_f_r} && req.duty_in <= 8'd100) begin
        freq_nxt = req.frequency_in[19:0]; duty_nxt = req.duty_in[6:0]; lok_nxt = 1'b1;
      end
      ACT_SAVED: if (req.save_ok) begin
        dirty_nxt = 1'b0; dtime_nxt = '0;
      end
      ACT_RETIME: dtime_nxt = req.now_ms;
      default: ;
    endcase
  end

  logic [31:0] f_eff;
  assign f_eff  = (freq_r == '0) ? 32'd1 : {12'd0, freq_r};
  assign dstart = cmd.div_start || dgo_r;
  always_comb begin
    if (cmd.div_start) begin
      dvd = CLK_W; dvs = f_eff;
    end else if (!phase_r) begin
      dvd = CLK_W; dvs = {16'd0, p_r} + 32'd1;
    end else begin
      dvd = ticks_r; dvs = f_eff;
    end
  end

  pts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(dvd), .divisor(dvs),
    .done(ddone), .quotient(quo)
  );

  // another trial is needed while the period does not fit
  assign more0   = (quo - 32'd1) > PMAX;
  assign more    = more0 && (p_r != 16'hFFFF);
  assign step_ok = srch_r && ddone && !dgo_r;
  assign dgo_nxt = (cmd.tm_start && quo != '0 && more0) ||
                   (!cmd.tm_start && step_ok && (!phase_r || (quo != '0 && more)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= FREQ_RESET; duty_r <= '0; dirty_r <= 1'b0; dtime_r <= '0; lok_r <= 1'b0;
      srch_r <= 1'b0; dgo_r <= 1'b0; phase_r <= 1'b0;
    end else begin
      dgo_r <= dgo_nxt;
      if (cmd.apply) begin
        freq_r <= freq_nxt; duty_r <= duty_nxt; dirty_r <= dirty_nxt;
        dtime_r <= dtime_nxt; lok_r <= lok_nxt;
      end
      if (cmd.tm_start) begin
        // first quotient clk/f is ready
        phase_r <= 1'b0;
        if (quo == '0) begin
          p_r <= '0; pre_r <= '0; per_r <= '0; srch_r <= 1'b0;
        end else if (more0) begin
          p_r <= 16'd1; srch_r <= 1'b1;
        end else begin
          p_r <= '0; pre_r <= '0; per_r <= quo[15:0] - 16'd1; srch_r <= 1'b0;
        end
      end else if (step_ok) begin
        if (!phase_r) begin
          // clk/(p+1) done: divide it by f next
          ticks_r <= quo; phase_r <= 1'b1;
        end else if (quo == '0) begin
          pre_r <= p_r; per_r <= '0; srch_r <= 1'b0;
        end else if (more) begin
          p_r <= p_r + 16'd1; phase_r <= 1'b0;
        end else begin
          pre_r <= p_r; per_r <= quo[15:0] - 16'd1; srch_r <= 1'b0;
        end
      end
    end
    if (cmd.pulse) num_r <= 24'(({8'd0, per_r} + 24'd1) * {17'd0, duty_r});
    if (cmd.pul_start) pulse_r <= pprod[46:30];
  end

  assign pprod = {24'd0, num_r} * {24'd0, PULSE_RECIP};

  assign sts.div_done    = ddone;
  assign sts.search_done = !srch_r;

  always_comb begin
    res.frequency_out  = freq_r;
    res.duty_out       = duty_r;
    res.prescaler_out  = pre_r;
    res.period_out     = per_r;
    res.pulse_out      = pulse_r;
    res.dirty_out      = dirty_r;
    res.dirty_time_out = dtime_r;
    res.load_ok        = lok_r;
  end
endmodule

### src/pts_ctrl.sv
// Sequencer for one request: apply, timer search, pulse, result.
module pts_ctrl import pts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  pts_sts_t sts,
  output pts_cmd_t cmd,
  output logic     load_res
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_DIV0 = 7'b0000010, S_WAIT0 = 7'b0000100,
    S_SRCH = 7'b0001000, S_PUL = 7'b0010000, S_PWAIT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;
  state_t st_r, st_nxt;
  logic ov_r, ov_nxt;

  always_comb begin
    st_nxt = st_r; ov_nxt = ov_r; cmd = '0; load_res = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_valid) begin
        cmd.apply = 1'b1; st_nxt = S_DIV0;
      end
      S_DIV0: begin cmd.div_start = 1'b1; st_nxt = S_WAIT0; end
      S_WAIT0: if (sts.div_done) begin cmd.tm_start = 1'b1; st_nxt = S_SRCH; end
      S_SRCH: if (sts.search_done && sts.div_done) begin
        cmd.pulse = 1'b1; st_nxt = S_PUL;
      end
      S_PUL: begin cmd.pul_start = 1'b1; st_nxt = S_PWAIT; end
      S_PWAIT: if (sts.div_done) st_nxt = S_DONE;
      S_DONE: if (!ov_r || !out_stall) begin
        load_res = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = ov_r;
endmodule

### src/pwm_timer_setting_controller.sv
// One request is processed at a time: in_stall stays high from accept until the result
// is loaded. Each prescaler trial runs two divisions on one shared restoring divider; one
// trial is needed per prescaler step above zero (about 1100 at 1 Hz and 72 MHz).
// A finished result waits in the output register while stalled; the next request is
// still accepted, and only its result is held back until that stall ends.
// Reset (rst_n, synchronous): frequency 10000, duty 0, clean, default limits.
`include "pwm_timer_setting_controller_defines.svh"
module pwm_timer_setting_controller import pts_pkg::*; #(
  parameter int unsigned CLOCK_HZ   = 72000000,
  parameter int unsigned PERIOD_MAX = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_req_t    out_data
);
  pts_cmd_t cmd;
  pts_sts_t sts;
  out_req_t res;
  logic     load_res;
  out_req_t out_r;

  pts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd),
    .load_res(load_res)
  );

  pts_datapath #(.CLOCK_HZ(CLOCK_HZ), .PERIOD_MAX(PERIOD_MAX)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_sel(cfg_index), .cfg_data(cfg_wdata),
    .req(in_data), .cmd(cmd), .sts(sts), .res(res)
  );

  always_ff @(posedge clk) begin
    if (load_res) out_r <= res;
  end
  assign out_data = out_r;

  `PTS_ASSERT(a_no_accept_busy, clk, rst_n, in_stall |-> !cmd.apply, "apply while busy")
  `PTS_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "result dropped")
  `PTS_ASSERT(a_load_after, clk, rst_n, load_res |=> out_valid, "result not shown")
endmodule

### sim/tb.sv
// Self-checking bench for the PWM timer setting controller: predicted vs. actual results.
module tb import pts_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLOCK_HZ   = 72000000;
  localparam int unsigned PERIOD_MAX = 65535;
  localparam int unsigned SETTLE_CYCLES = 200;

  class pwm_setting_predictor;
    logic [31:0] min_freq = 1000, max_freq = 200000, freq_step = 1000, duty_step = 1;
    logic [31:0] freq = 10000, duty = 0, prescaler = 0, period = 7199;
    logic        dirty = 0;
    logic [31:0] dirty_time = 0;
    out_req_t    expected_results[$];
    int          errors = 0;

    function void set_reg(cfg_idx_t idx, logic [19:0] value);
      case (idx)
        CFG_MIN_FREQ:  min_freq  = {12'd0, value};
        CFG_MAX_FREQ:  max_freq  = {12'd0, value};
        CFG_FREQ_STEP: freq_step = {12'd0, value};
        CFG_DUTY_STEP: duty_step = {25'd0, value[6:0]};
        default: ;
      endcase
    endfunction

    function void timer_values();
      logic [31:0] f, p, ticks;
      f = (freq != 0) ? freq : 32'd1;
      p = 0;
      ticks = CLOCK_HZ / f;
      if (ticks == 0) begin
        prescaler = 0;
        period = 0;
        return;
      end
      while (ticks - 1 > PERIOD_MAX && p < 65535) begin
        p++;
        ticks = (CLOCK_HZ / (p + 1)) / f;
        if (ticks == 0) begin
          ticks = 1;
          break;
        end
      end
      prescaler = p & 32'hFFFF;
      period = (ticks - 1) & 32'hFFFF;
    endfunction

    function void apply_freq(logic [31:0] f, logic [31:0] now);
      if (f < min_freq) f = min_freq;
      if (f > max_freq) f = max_freq;
      freq = f & 32'hFFFFF;
      dirty = 1;
      dirty_time = now;
    endfunction

    function void apply_duty(logic [31:0] d, logic [31:0] now);
      if (d > 100) d = 100;
      duty = d;
      dirty = 1;
      dirty_time = now;
    endfunction

    // Advance the state by one accepted request and queue its result.
    function void note_request(in_req_t r);
      logic [31:0] t, fin, din;
      out_req_t    res;
      logic        loaded;
      loaded = 0;
      fin = r.frequency_in;
      din = {24'd0, r.duty_in};
      case (r.action)
        ACT_SETFREQ: apply_freq(fin, r.now_ms);
        ACT_SETDUTY: apply_duty(din, r.now_ms);
        ACT_INCFREQ: begin
          t = freq + freq_step;
          if (t <= max_freq) apply_freq(t, r.now_ms);
        end
        ACT_DECFREQ: begin
          if (freq_step <= freq) begin
            t = freq - freq_step;
            if (t >= min_freq) apply_freq(t, r.now_ms);
          end
        end
        ACT_INCDUTY: begin
          t = duty + duty_step;
          if (t <= 100) apply_duty(t, r.now_ms);
        end
        ACT_DECDUTY: if (duty_step <= duty) apply_duty(duty - duty_step, r.now_ms);
        ACT_LOAD: begin
          if (r.record_magic == RECORD_MAGIC &&
              r.record_checksum == (r.record_magic ^ fin ^ din) &&
              fin >= min_freq && fin <= max_freq && din <= 100) begin
            freq = fin & 32'hFFFFF;
            duty = din;
            loaded = 1;
          end
        end
        ACT_SAVED: begin
          if (r.save_ok) begin
            dirty = 0;
            dirty_time = 0;
          end
        end
        ACT_RETIME: dirty_time = r.now_ms;
        default: ;
      endcase
      timer_values();
      res.frequency_out  = freq[19:0];
      res.duty_out       = duty[6:0];
      res.prescaler_out  = prescaler[15:0];
      res.period_out     = period[15:0];
      t = ((period + 1) * duty) / 100;
      res.pulse_out      = t[16:0];
      res.dirty_out      = dirty;
      res.dirty_time_out = dirty_time;
      res.load_ok        = loaded;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_req_t a);
      out_req_t e;
      if (expected_results.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      e = expected_results.pop_front();
      compare_field("frequency_out", e.frequency_out, a.frequency_out);
      compare_field("duty_out", e.duty_out, a.duty_out);
      compare_field("prescaler_out", e.prescaler_out, a.prescaler_out);
      compare_field("period_out", e.period_out, a.period_out);
      compare_field("pulse_out", e.pulse_out, a.pulse_out);
      compare_field("dirty_out", e.dirty_out, a.dirty_out);
      compare_field("dirty_time_out", e.dirty_time_out, a.dirty_time_out);
      compare_field("load_ok", e.load_ok, a.load_ok);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_wdata = '0;
  logic        in_valid = 0;
  logic        in_stall;
  in_req_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_req_t    out_data;

  pwm_setting_predictor model = new();

  pwm_timer_setting_controller i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver stall pattern: switch between free-flowing, coin-flip and long stalls.
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 300 == 299) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      default: out_stall <= (stall_cnt % 64) < 40;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) model.check_result(out_data);
  end

  task automatic write_reg(cfg_idx_t idx, logic [19:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic write_limits(logic [19:0] lo, logic [19:0] hi, logic [19:0] fs,
                              logic [19:0] ds);
    write_reg(CFG_MIN_FREQ, lo);
    write_reg(CFG_MAX_FREQ, hi);
    write_reg(CFG_FREQ_STEP, fs);
    write_reg(CFG_DUTY_STEP, ds);
  endtask

  // Present one request and hold it until taken.
  task automatic send(in_req_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    model.note_request(r);
  endtask

  task automatic pause(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_req_t noise_req();
    in_req_t r;
    r.action          = $urandom_range(0, 15);
    r.frequency_in    = $urandom;
    r.duty_in         = $urandom_range(0, 255);
    r.now_ms          = $urandom;
    r.record_magic    = $urandom;
    r.record_checksum = $urandom;
    r.save_ok         = $urandom_range(0, 1);
    return r;
  endfunction

  function automatic in_req_t cmd(action_t a, logic [31:0] f, logic [7:0] d);
    in_req_t r;
    r = noise_req();
    r.action = a;
    r.frequency_in = f;
    r.duty_in = d;
    return r;
  endfunction

  function automatic in_req_t record(logic [31:0] f, logic [7:0] d);
    in_req_t r;
    r = cmd(ACT_LOAD, f, d);
    r.record_magic = RECORD_MAGIC;
    r.record_checksum = RECORD_MAGIC ^ f ^ {24'd0, d};
    return r;
  endfunction

  function automatic logic [31:0] freq_in_range();
    if (model.min_freq <= model.max_freq && $urandom_range(0, 3) != 0)
      return $urandom_range(model.min_freq, model.max_freq);
    return $urandom;
  endfunction

  function automatic in_req_t random_req();
    in_req_t r;
    int      k;
    k = $urandom_range(0, 99);
    r = noise_req();
    if (k < 15) r = cmd(ACT_SETFREQ, freq_in_range(), $urandom);
    else if (k < 28) r.action = ACT_SETDUTY;
    else if (k < 38) r.action = ACT_INCFREQ;
    else if (k < 48) r.action = ACT_DECFREQ;
    else if (k < 58) r.action = ACT_INCDUTY;
    else if (k < 68) r.action = ACT_DECDUTY;
    else if (k < 82) begin
      r = record(freq_in_range(), $urandom_range(0, 100));
      // corrupt a share of the records
      case ($urandom_range(0, 5))
        0: r.record_magic[$urandom_range(0, 31)] ^= 1'b1;
        1: r.record_checksum[$urandom_range(0, 31)] ^= 1'b1;
        2: begin
          r.duty_in = $urandom_range(101, 255);
          r.record_checksum = RECORD_MAGIC ^ r.frequency_in ^ {24'd0, r.duty_in};
        end
        default: ;
      endcase
    end
    else if (k < 88) r.action = ACT_SAVED;
    else if (k < 94) r.action = ACT_RETIME;
    return r;
  endfunction

  task automatic random_phase(int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send(random_req());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
      if (sent >= n / 2 && sent < n / 2 + burst) begin
        // hold the sender until everything outstanding is back
        in_valid <= 1'b0;
        @(posedge clk);
        while (model.expected_results.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults, directed
    send(cmd(ACT_RETIME, 0, 0));
    send(cmd(ACT_SETDUTY, 0, 8'd255));
    send(cmd(ACT_INCDUTY, 0, 0));
    send(cmd(ACT_DECDUTY, 0, 0));
    send(cmd(ACT_SETFREQ, 32'hFFFF_FFFF, 8'd50));
    send(cmd(ACT_INCFREQ, 0, 0));
    send(cmd(ACT_SETFREQ, 0, 0));
    send(cmd(ACT_DECFREQ, 0, 0));
    send(record(32'd20000, 8'd100));
    send(record(32'd20000, 8'd101));
    send(record(32'd500, 8'd10));
    send(record(32'd300000, 8'd10));
    begin
      in_req_t r;
      r = record(32'd5000, 8'd0);
      r.record_magic = ~RECORD_MAGIC;
      send(r);
      r = record(32'd5000, 8'd0);
      r.record_checksum = 0;
      send(r);
      r = cmd(ACT_SAVED, 0, 0);
      r.save_ok = 1'b0;
      send(r);
      r.save_ok = 1'b1;
      send(r);
    end
    send(cmd(action_t'(4'd9), 0, 0));
    send(cmd(action_t'(4'd15), 32'hFFFF_FFFF, 8'hFF));
    drain();

    // widest limits, lowest frequencies, step larger than the frequency
    write_limits(20'd1, 20'hFFFFF, 20'hFFFFF, 7'd100);
    send(cmd(ACT_SETFREQ, 32'd1, 8'd0));
    send(cmd(ACT_INCDUTY, 0, 0));
    send(cmd(ACT_DECFREQ, 0, 0));
    send(cmd(ACT_SETFREQ, 32'd50, 0));
    send(cmd(ACT_SETFREQ, 32'hFFFFF, 0));
    send(cmd(ACT_DECDUTY, 0, 0));
    send(cmd(ACT_DECFREQ, 0, 0));
    send(record(32'd100000, 8'd37));
    drain();

    // min above max, zero steps
    write_limits(20'd300000, 20'd2000, 20'd0, 7'd0);
    send(cmd(ACT_SETFREQ, 32'd123456, 0));
    send(cmd(ACT_INCFREQ, 0, 0));
    send(cmd(ACT_DECDUTY, 0, 0));
    drain();

    write_limits(20'd500, 20'hFFFFF, 20'd4096, 7'd7);
    random_phase(100);
    drain();
    write_limits($urandom_range(500, 20000), $urandom_range(20000, 1048575),
                 $urandom_range(0, 50000), $urandom_range(0, 100));
    random_phase(100);
    drain();
    write_limits(20'd50000, 20'd50000, 20'd1, 7'd100);
    random_phase(30);
    drain();
    write_limits($urandom_range(500, 5000), $urandom_range(100000, 1048575),
                 $urandom_range(1, 2000), $urandom_range(1, 20));
    random_phase(80);
    drain();

    if (model.errors == 0 && model.expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
